>>> design/accpd_pkg.sv
// Package for the activity peak decay block: widths, register indexes, sequencer states.
package accpd_pkg;

  // Default number of peak entries.
  localparam int unsigned MaxSensorsDefault = 16;

  // Field widths.
  localparam int unsigned AxisW   = 14;
  localparam int unsigned IndexW  = 4;
  localparam int unsigned LevelW  = 13;
  localparam int unsigned DecayW  = 16;
  localparam int unsigned CountW  = 5;
  localparam int unsigned InDataW = 48;
  localparam int unsigned OutDataW = 16;

  // Arithmetic widths.
  localparam int unsigned SumW  = 28;
  localparam int unsigned ProdW = AxisW + DecayW;

  // One g in 1/1024 g units.
  localparam logic [AxisW-1:0] OneG = 14'd1024;

  // Reciprocal of three in Q0.16, rounded up; exact for values below 32768.
  localparam logic [DecayW-1:0] Div3Recip = 16'd21846;

  // Top bit of the square root sweep (radicand stays below 2**28).
  localparam logic [SumW-1:0] SqrtFirstBit = 28'h400_0000;

  // Configuration register indexes.
  localparam int unsigned CfgAddrW = 1;
  localparam logic [CfgAddrW-1:0] RegDecayFactor = 1'b0;
  localparam logic [CfgAddrW-1:0] RegSensorCount = 1'b1;

  // Register reset values.
  localparam logic [DecayW-1:0] DecayReset = 16'd0;
  localparam logic [CountW-1:0] CountReset = 5'd16;

  // Sequencer states.
  typedef enum logic [2:0] {
    StIdle,
    StSquare,
    StRoot,
    StDiv,
    StPeak,
    StDecay,
    StOut
  } state_e;

endpackage

>>> design/accel_activity_peak_decay.sv
// Top level: activity level with a per-sensor decaying peak, one shared multiplier.
//
//  Channel   Direction  Signals                                 Contents
//  s_axis    in         s_axis_tvalid/tready/tdata/tuser        one sample
//  m_axis    out        m_axis_tvalid/tready/tdata              one result
//  cfg       in         cfg_valid/ready/addr/data               register writes
//
// An item goes from its accepting cycle to a loaded result register in steps: it is
// accepted, three multiplier passes form the squares, fourteen steps of the bit-serial
// square root follow, then one multiplier pass for the divide by three, in mode 1 a
// compare with the peak and one more multiplier pass when the peak decays, and last
// the load of the result. A rejected index goes straight to the result register.
// Reset clears the peak store, the configuration registers and the result valid.
// A stalled result holds the sequencer in its last state; the configuration port is
// always ready.
module accel_activity_peak_decay #(
  parameter int unsigned MAX_SENSORS = accpd_pkg::MaxSensorsDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Sample transactions.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata from bit 0: sensor_index[3:0], accel_x[17:4], accel_y[31:18],
  // accel_z[45:32], zero fill[47:46].
  input  logic [accpd_pkg::InDataW-1:0]      s_axis_tdata,
  // tuser: mode[0].
  input  logic                               s_axis_tuser,
  // Result transactions.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata from bit 0: level[12:0], new_peak[13], index_error[14], zero fill[15].
  output logic [accpd_pkg::OutDataW-1:0]     m_axis_tdata,
  // Configuration write transactions.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [accpd_pkg::CfgAddrW-1:0]     cfg_addr,
  input  logic [accpd_pkg::DecayW-1:0]       cfg_data
);
  import accpd_pkg::*;

  localparam int unsigned PeakIdxW = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int unsigned WideIdxW = (PeakIdxW > IndexW) ? PeakIdxW : IndexW;
  localparam int unsigned CmpW     = 8;

  // Registers.
  state_e                state_q, state_d;
  logic [DecayW-1:0]     decay_q;
  logic [CountW-1:0]     count_q;
  logic [LevelW-1:0]     peak_q [MAX_SENSORS];
  logic                  mode_q, mode_d;
  logic [PeakIdxW-1:0]   idx_q, idx_d;
  logic [AxisW-1:0]      ax_q, ax_d, ay_q, ay_d, az_q, az_d;
  logic [1:0]            cnt_q, cnt_d;
  logic [SumW-1:0]       rem_q, rem_d;
  logic [SumW-1:0]       root_q, root_d;
  logic [SumW-1:0]       bit_q, bit_d;
  logic [LevelW-1:0]     act_q, act_d;
  logic [LevelW-1:0]     res_level_q, res_level_d;
  logic                  res_np_q, res_np_d;
  logic                  res_err_q, res_err_d;
  logic                  out_valid_q, out_valid_d;
  logic [OutDataW-1:0]   out_data_q, out_data_d;
  logic                  peak_we;
  logic [LevelW-1:0]     peak_wdata;

  // Input field views.
  logic [IndexW-1:0]     in_idx;
  logic [AxisW-1:0]      in_x, in_y, in_z;
  logic [WideIdxW-1:0]   in_idx_wide;
  logic                  in_accept, in_idx_ok, out_free;

  // Shared multiplier and datapath nets.
  logic [AxisW-1:0]      mul_a;
  logic [DecayW-1:0]     mul_b;
  logic [ProdW-1:0]      mul_p;
  logic [AxisW-1:0]      dev;
  logic [SumW-1:0]       trial;
  logic [LevelW-1:0]     peak_rd;

  assign in_idx      = s_axis_tdata[IndexW-1:0];
  assign in_x        = s_axis_tdata[IndexW +: AxisW];
  assign in_y        = s_axis_tdata[IndexW + AxisW +: AxisW];
  assign in_z        = s_axis_tdata[IndexW + 2*AxisW +: AxisW];
  assign in_idx_wide = WideIdxW'(in_idx);
  assign in_idx_ok   = (CmpW'(in_idx) < CmpW'(count_q)) && (CmpW'(in_idx) < CmpW'(MAX_SENSORS));

  assign s_axis_tready = (state_q == StIdle);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign cfg_ready     = 1'b1;

  assign peak_rd = peak_q[idx_q];
  assign dev     = (root_q[AxisW-1:0] >= OneG) ? (root_q[AxisW-1:0] - OneG)
                                               : (OneG - root_q[AxisW-1:0]);
  assign trial   = root_q + bit_q;

  // Absolute value of a two's complement axis field; -8192 maps to 8192.
  function automatic logic [AxisW-1:0] abs_axis(input logic [AxisW-1:0] v);
    abs_axis = v[AxisW-1] ? (~v + AxisW'(1)) : v;
  endfunction

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      StSquare: begin
        case (cnt_q)
          2'd0:    mul_a = ax_q;
          2'd1:    mul_a = ay_q;
          default: mul_a = az_q;
        endcase
        mul_b = DecayW'(mul_a);
      end
      StDiv: begin
        mul_a = dev;
        mul_b = Div3Recip;
      end
      StDecay: begin
        mul_a = AxisW'(peak_rd);
        mul_b = decay_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = ProdW'(mul_a) * ProdW'(mul_b);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_accept) begin
          state_d = in_idx_ok ? StSquare : StOut;
        end
      end
      StSquare: begin
        if (cnt_q == 2'd2) begin
          state_d = StRoot;
        end
      end
      StRoot: begin
        if (bit_q[0]) begin
          state_d = StDiv;
        end
      end
      StDiv: begin
        state_d = mode_q ? StPeak : StOut;
      end
      StPeak: begin
        state_d = (act_q > peak_rd) ? StOut : StDecay;
      end
      StDecay: begin
        state_d = StOut;
      end
      StOut: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Datapath updates per state.
  always_comb begin
    mode_d      = mode_q;
    idx_d       = idx_q;
    ax_d        = ax_q;
    ay_d        = ay_q;
    az_d        = az_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    root_d      = root_q;
    bit_d       = bit_q;
    act_d       = act_q;
    res_level_d = res_level_q;
    res_np_d    = res_np_q;
    res_err_d   = res_err_q;
    peak_we     = 1'b0;
    peak_wdata  = act_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    // The consumer takes the result.
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_accept) begin
          mode_d      = s_axis_tuser;
          idx_d       = in_idx_wide[PeakIdxW-1:0];
          ax_d        = abs_axis(in_x);
          ay_d        = abs_axis(in_y);
          az_d        = abs_axis(in_z);
          cnt_d       = '0;
          rem_d       = '0;
          res_level_d = '0;
          res_np_d    = 1'b0;
          res_err_d   = !in_idx_ok;
        end
      end
      StSquare: begin
        // Accumulate one axis square per cycle.
        rem_d = rem_q + mul_p[SumW-1:0];
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd2) begin
          root_d = '0;
          bit_d  = SqrtFirstBit;
        end
      end
      StRoot: begin
        // One bit-serial square root step.
        if (rem_q >= trial) begin
          rem_d  = rem_q - trial;
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
      end
      StDiv: begin
        // Divide the deviation from one g by three.
        act_d       = mul_p[DecayW +: LevelW];
        res_level_d = mul_p[DecayW +: LevelW];
      end
      StPeak: begin
        if (act_q > peak_rd) begin
          peak_we    = 1'b1;
          peak_wdata = act_q;
          res_np_d   = 1'b1;
        end
      end
      StDecay: begin
        // Scale the stored peak by the Q0.16 decay factor.
        peak_we     = 1'b1;
        peak_wdata  = mul_p[DecayW +: LevelW];
        res_level_d = mul_p[DecayW +: LevelW];
      end
      StOut: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {1'b0, res_err_q, res_np_q, res_level_q};
        end
      end
      default: begin
        peak_we = 1'b0;
      end
    endcase
  end

  // Control state and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      decay_q     <= DecayReset;
      count_q     <= CountReset;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          RegDecayFactor: decay_q <= cfg_data;
          RegSensorCount: count_q <= cfg_data[CountW-1:0];
          default:        decay_q <= decay_q;
        endcase
      end
    end
  end

  // Peak store, cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_SENSORS; i++) begin
        peak_q[i] <= '0;
      end
    end else if (peak_we) begin
      peak_q[idx_q] <= peak_wdata;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    idx_q       <= idx_d;
    ax_q        <= ax_d;
    ay_q        <= ay_d;
    az_q        <= az_d;
    cnt_q       <= cnt_d;
    rem_q       <= rem_d;
    root_q      <= root_d;
    bit_q       <= bit_d;
    act_q       <= act_d;
    res_level_q <= res_level_d;
    res_np_q    <= res_np_d;
    res_err_q   <= res_err_d;
    out_data_q  <= out_data_d;
  end

endmodule

>>> tb/accel_activity_peak_decay_test.sv
// Self-checking testbench for the activity level and decaying peak block.
module accel_activity_peak_decay_test;
  import accpd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One result transaction as the block reports it.
  typedef struct packed {
    logic              index_error;
    logic              new_peak;
    logic [LevelW-1:0] level;
  } activity_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [InDataW-1:0]    s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OutDataW-1:0]   m_axis_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CfgAddrW-1:0]   cfg_addr;
  logic [DecayW-1:0]     cfg_data;

  // Shadow copy of the registers and the peak store.
  logic [DecayW-1:0]     decay_q;
  logic [CountW-1:0]     count_q;
  logic [LevelW-1:0]     peak_mem [MaxSensorsDefault];

  activity_result_t      expected_levels [$];
  activity_result_t      want;
  int unsigned           mismatch_count;
  logic                  idling_on;
  int unsigned           ready_hold;

  accel_activity_peak_decay i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #6_000_000;
    $display("FAIL");
    $finish;
  end

  // Computes the expected result of one sample and updates the shadow peak store.
  function automatic activity_result_t predict_activity(input logic mode,
                                                        input logic [IndexW-1:0] idx,
                                                        input logic signed [AxisW-1:0] ax,
                                                        input logic signed [AxisW-1:0] ay,
                                                        input logic signed [AxisW-1:0] az);
    activity_result_t res;
    int               sx;
    int               sy;
    int               sz;
    longint           sum;
    longint           root;
    longint           trial;
    int unsigned      dev;
    int unsigned      act;
    res = '0;
    if ({1'b0, idx} >= count_q) begin
      res.index_error = 1'b1;
      return res;
    end
    sx = ax;
    sy = ay;
    sz = az;
    sum = longint'(sx * sx) + longint'(sy * sy) + longint'(sz * sz);
    // Build the floor square root from the top bit down.
    root = 0;
    for (int b = 14; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= sum) root = trial;
    end
    dev = (root >= 1024) ? int'(root) - 1024 : 1024 - int'(root);
    act = dev / 3;
    if (!mode) begin
      res.level = LevelW'(act);
    end else if (act > peak_mem[idx]) begin
      peak_mem[idx] = LevelW'(act);
      res.level = LevelW'(act);
      res.new_peak = 1'b1;
    end else begin
      // A peak that is only matched or undercut decays.
      peak_mem[idx] = LevelW'((32'(peak_mem[idx]) * 32'(decay_q)) >> 16);
      res.level = peak_mem[idx];
    end
    return res;
  endfunction

  // Logs a failed comparison; only the first ten are printed.
  task automatic note_mismatch(input string msg);
    if (mismatch_count < 10) $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  // Sends one sample transaction and records its expected result on acceptance.
  task automatic send_sample(input logic mode, input logic [IndexW-1:0] idx,
                             input logic signed [AxisW-1:0] ax,
                             input logic signed [AxisW-1:0] ay,
                             input logic signed [AxisW-1:0] az);
    int unsigned gap;
    if (idling_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 16);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, az, ay, ax, idx};
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_levels.push_back(predict_activity(mode, idx, ax, ay, az));
  endtask

  // Holds off the sender until every result is back and the block has settled.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
  endtask

  // Drives one register write transaction; the caller lowers the valid.
  task automatic write_register(input logic [CfgAddrW-1:0] addr, input logic [DecayW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    if (addr == RegDecayFactor) decay_q = value;
    else count_q = value[CountW-1:0];
  endtask

  // Writes both registers while the block is idle.
  task automatic configure(input logic [DecayW-1:0] decay, input logic [CountW-1:0] count);
    drain_results();
    write_register(RegDecayFactor, decay);
    write_register(RegSensorCount, DecayW'(count));
    cfg_valid <= 1'b0;
  endtask

  // Axis extremes, a sample at rest, and both modes under the reset settings.
  task automatic test_axis_extremes();
    send_sample(1'b0, 4'd0, -14'sd8192, -14'sd8192, -14'sd8192);
    send_sample(1'b0, 4'd15, 14'sd8191, 14'sd8191, 14'sd8191);
    send_sample(1'b0, 4'd7, 14'sd0, 14'sd0, 14'sd0);
    send_sample(1'b0, 4'd1, 14'sd0, 14'sd0, 14'sd1024);
    send_sample(1'b0, 4'd2, 14'sd0, -14'sd1024, 14'sd0);
    send_sample(1'b1, 4'd0, -14'sd8192, 14'sd0, 14'sd0);
    send_sample(1'b1, 4'd0, 14'sd8191, -14'sd8192, 14'sd8191);
    // Zero decay factor after reset: an unbeaten peak collapses to zero.
    send_sample(1'b1, 4'd0, 14'sd0, 14'sd0, 14'sd1024);
    send_sample(1'b1, 4'd15, 14'sd0, 14'sd0, 14'sd0);
  endtask

  // New peaks, an equal activity that decays, and the decay factor extremes.
  task automatic test_peak_tracking();
    configure(16'h8000, 5'd16);
    send_sample(1'b1, 4'd3, 14'sd0, 14'sd0, 14'sd4096);
    send_sample(1'b1, 4'd3, 14'sd0, 14'sd0, 14'sd4096);
    send_sample(1'b1, 4'd3, 14'sd0, 14'sd0, 14'sd1324);
    send_sample(1'b1, 4'd3, 14'sd5000, 14'sd0, 14'sd0);
    configure(16'hFFFF, 5'd16);
    send_sample(1'b1, 4'd3, 14'sd0, 14'sd0, 14'sd1024);
    send_sample(1'b1, 4'd3, 14'sd0, 14'sd0, 14'sd1024);
    configure(16'h0000, 5'd16);
    send_sample(1'b1, 4'd3, 14'sd0, 14'sd0, 14'sd1024);
  endtask

  // Rejected indexes, a zero sensor count and a count above the store size.
  task automatic test_index_limits();
    configure(16'h1234, 5'd4);
    send_sample(1'b1, 4'd3, 14'sd3000, 14'sd0, 14'sd0);
    send_sample(1'b1, 4'd4, 14'sd3000, 14'sd0, 14'sd0);
    send_sample(1'b0, 4'd15, 14'sd0, 14'sd0, 14'sd0);
    configure(16'h1234, 5'd0);
    send_sample(1'b0, 4'd0, 14'sd100, 14'sd0, 14'sd0);
    configure(16'h1234, 5'd31);
    send_sample(1'b1, 4'd15, 14'sd6000, 14'sd0, 14'sd0);
    configure(16'h1234, 5'd1);
    send_sample(1'b0, 4'd0, 14'sd0, 14'sd0, 14'sd0);
    send_sample(1'b0, 4'd1, 14'sd0, 14'sd0, 14'sd0);
  endtask

  // Returns a random axis value around center, spread by span either way.
  function automatic logic signed [AxisW-1:0] near(input int center, input int span);
    return AxisW'(center + int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // Random samples over a series of register settings.
  task automatic test_random_traffic();
    logic [DecayW-1:0]        decay;
    logic [CountW-1:0]        count;
    int unsigned              items;
    logic [IndexW-1:0]        idx;
    logic signed [AxisW-1:0]  ax;
    logic signed [AxisW-1:0]  ay;
    logic signed [AxisW-1:0]  az;
    int                       sign;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin decay = 16'h0000; count = 5'd16; items = 300; end
        1: begin decay = 16'hFFFF; count = 5'd16; items = 300; end
        2: begin decay = DecayW'($urandom); count = 5'd1; items = 150; end
        3: begin decay = DecayW'($urandom); count = 5'd0; items = 20; end
        4: begin decay = DecayW'($urandom); count = 5'd31; items = 300; end
        5: begin decay = 16'hC000; count = CountW'($urandom_range(2, 15)); items = 300; end
        6: begin decay = DecayW'($urandom); count = CountW'($urandom_range(1, 16)); items = 330; end
        default: begin decay = DecayW'($urandom); count = 5'd16; items = 250; end
      endcase
      configure(decay, count);
      // The closing stretch runs with neither side idling.
      idling_on = (p != 7);
      repeat (items) begin
        if (count == 0 || $urandom_range(0, 4) == 0) idx = IndexW'($urandom);
        else idx = IndexW'($urandom_range(0, (count > 16 ? 16 : count) - 1));
        sign = $urandom_range(0, 1) ? 1 : -1;
        case ($urandom_range(0, 3))
          0: begin
            ax = AxisW'($urandom); ay = AxisW'($urandom); az = AxisW'($urandom);
          end
          1: begin
            ax = near(0, 200); ay = near(0, 200); az = near(sign * 1024, 150);
          end
          2: begin
            ax = near(0, 3000); ay = near(0, 3000); az = near(0, 3000);
          end
          default: begin
            ax = near(sign * 8000, 191); ay = near(0, 8191); az = near(-sign * 7000, 1191);
          end
        endcase
        send_sample($urandom_range(0, 3) != 0, idx, ax, ay, az);
      end
    end
  endtask

  // Result checker: each result transaction against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_levels.size() == 0) begin
        note_mismatch($sformatf("unexpected result tdata=%h", m_axis_tdata));
      end else begin
        want = expected_levels.pop_front();
        if (m_axis_tdata[LevelW-1:0] !== want.level ||
            m_axis_tdata[LevelW] !== want.new_peak ||
            m_axis_tdata[LevelW+1] !== want.index_error) begin
          note_mismatch($sformatf("level %0d/%0d new_peak %b/%b index_error %b/%b (exp/act)",
                                  want.level, m_axis_tdata[LevelW-1:0],
                                  want.new_peak, m_axis_tdata[LevelW],
                                  want.index_error, m_axis_tdata[LevelW+1]));
        end
      end
    end
  end

  // Receiver stalls in random bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      ready_hold    <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (idling_on && $urandom_range(0, 11) == 0) begin
      m_axis_tready <= 1'b0;
      ready_hold    <= $urandom_range(0, 15);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Test sequence.
  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = 1'b0;
    cfg_valid      = 1'b0;
    cfg_addr       = RegDecayFactor;
    cfg_data       = '0;
    decay_q        = DecayReset;
    count_q        = CountReset;
    mismatch_count = 0;
    idling_on      = 1'b1;
    foreach (peak_mem[i]) peak_mem[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_axis_extremes();
    test_peak_tracking();
    test_index_limits();
    test_random_traffic();
    drain_results();
    if (mismatch_count == 0 && expected_levels.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
